FILE: rtl/core/linear_congruence_solver_defines.svh
// ----------------------------------------------------------------------------
// linear_congruence_solver_defines
// assertion macros shared by the solver's rtl; they expect clk and rst in scope
// ----------------------------------------------------------------------------
`ifndef LINEAR_CONGRUENCE_SOLVER_DEFINES_SVH
`define LINEAR_CONGRUENCE_SOLVER_DEFINES_SVH

// same-cycle implication
`define LCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcs assertion failed");

// next-cycle implication
`define LCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcs assertion failed");

`endif

FILE: rtl/core/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// types and constants for the linear congruence solver
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int LCS_OPERAND_WIDTH = 31;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_ALIGN,
    DIV_SUB
  } lcs_div_phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EUC_CHK,
    S_EUC_WAIT,
    S_RHS_WAIT,
    S_MOD_LAUNCH,
    S_MOD_WAIT,
    S_REDUCE,
    S_MUL_WAIT,
    S_FINISH
  } lcs_state_t;

endpackage

FILE: rtl/core/lcs_divider.sv
// ----------------------------------------------------------------------------
// lcs_divider
// shared shift-subtract divider; alongside the remainder it accumulates
// t_init - quotient * t_step, which gives both euclid cofactors and quotients
// ----------------------------------------------------------------------------
`include "linear_congruence_solver_defines.svh"

module lcs_divider #(
  parameter int W = lcs_pkg::LCS_OPERAND_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [W-1:0]        dividend,
  input  logic [W-1:0]        divisor,
  input  logic signed [W+1:0] t_init,
  input  logic signed [W+1:0] t_step,
  output logic                done,
  output logic [W-1:0]        remainder,
  output logic signed [W+1:0] t_acc
);
  import lcs_pkg::*;

  localparam int CW = $clog2(W);

  lcs_div_phase_t       phase, phase_next;
  logic [W-1:0]         rem;
  logic [W-1:0]         ds;
  logic signed [W+1:0]  ts;
  logic signed [W+1:0]  tacc;
  logic [CW-1:0]        k;
  logic                 grow;
  logic                 fits;
  logic [W-1:0]         rem_sub;
  logic signed [W+1:0]  tacc_sub;

  // divisor is shifted up until doubling it would pass the remainder
  assign grow     = ({ds, 1'b0} <= {1'b0, rem});
  assign fits     = (rem >= ds);
  assign rem_sub  = rem - ds;
  assign tacc_sub = tacc - ts;

  always_comb begin
    phase_next = phase;
    case (phase)
      DIV_IDLE:  if (start) phase_next = DIV_ALIGN;
      DIV_ALIGN: if (!grow) phase_next = DIV_SUB;
      DIV_SUB:   if (k == '0) phase_next = DIV_IDLE;
      default:   phase_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    done      = (phase == DIV_SUB) && (k == '0);
    remainder = fits ? rem_sub : rem;
    t_acc     = fits ? tacc_sub : tacc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= DIV_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      DIV_IDLE: begin
        if (start) begin
          rem  <= dividend;
          ds   <= divisor;
          ts   <= t_step;
          tacc <= t_init;
          k    <= '0;
        end
      end
      DIV_ALIGN: begin
        if (grow) begin
          ds <= {ds[W-2:0], 1'b0};
          ts <= ts <<< 1;
          k  <= k + CW'(1);
        end
      end
      DIV_SUB: begin
        if (fits) begin
          rem  <= rem_sub;
          tacc <= tacc_sub;
        end
        if (k != '0) begin
          ds <= ds >> 1;
          ts <= ts >>> 1;
          k  <= k - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  `LCS_ASSERT_IMP(a_start_when_idle, start, phase == DIV_IDLE)
  `LCS_ASSERT_NEXT(a_done_then_idle, done, phase == DIV_IDLE)
  `LCS_ASSERT_IMP(a_sub_bound, phase == DIV_SUB, ({1'b0, rem} < {ds, 1'b0}))

endmodule

FILE: rtl/core/lcs_mulmod.sv
// ----------------------------------------------------------------------------
// lcs_mulmod
// modular multiply by shift and add, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module lcs_mulmod #(
  parameter int W = lcs_pkg::LCS_OPERAND_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] mult_a,
  input  logic [W-1:0] mult_b,
  input  logic [W-1:0] modv,
  output logic         done,
  output logic [W-1:0] product
);
  import lcs_pkg::*;

  logic         busy;
  logic [W-1:0] acc;
  logic [W-1:0] p;
  logic [W-1:0] q;
  logic [W-1:0] m;
  logic [W:0]   acc_sum;
  logic [W:0]   p_dbl;
  logic [W-1:0] acc_next;
  logic [W-1:0] p_next;

  // both operands stay below m, so one conditional subtract suffices
  always_comb begin
    acc_sum  = {1'b0, acc} + {1'b0, p};
    p_dbl    = {p, 1'b0};
    acc_next = (acc_sum >= {1'b0, m}) ? W'(acc_sum - {1'b0, m}) : acc_sum[W-1:0];
    p_next   = (p_dbl >= {1'b0, m}) ? W'(p_dbl - {1'b0, m}) : p_dbl[W-1:0];
    done     = busy && (q == '0);
    product  = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      p   <= mult_a;
      q   <= mult_b;
      m   <= modv;
    end else if (busy && (q != '0)) begin
      if (q[0]) begin
        acc <= acc_next;
      end
      p <= p_next;
      q <= q >> 1;
    end
  end

endmodule

FILE: rtl/core/linear_congruence_solver.sv
// ----------------------------------------------------------------------------
// linear_congruence_solver: solves coef*x = rhs (mod modulus) by extended euclid
// a zero modulus goes straight to the output; else the shared divider runs the euclid
//   steps, then divides rhs and modulus by the gcd, then the product is formed mod the
//   reduced modulus and registered (if the gcd misses rhs, the result is registered at once)
// a request is taken only in idle; synchronous reset clears the sequencer and out_valid
// ----------------------------------------------------------------------------
`include "linear_congruence_solver_defines.svh"

module linear_congruence_solver #(
  parameter int OPERAND_WIDTH = lcs_pkg::LCS_OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OPERAND_WIDTH-1:0] coef,
  input  logic [OPERAND_WIDTH-1:0] rhs,
  input  logic [OPERAND_WIDTH-1:0] modulus,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     has_solution,
  output logic [OPERAND_WIDTH-1:0] solution
);
  import lcs_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int TW = OPERAND_WIDTH + 2;

  lcs_state_t            state, state_next;
  logic                  in_accept;
  logic                  out_load;

  logic [W-1:0]          b_reg;
  logic [W-1:0]          n_reg;
  logic [W-1:0]          r0;
  logic [W-1:0]          r1;
  logic signed [TW-1:0]  t0;
  logic signed [TW-1:0]  t1;
  logic [W-1:0]          qb;
  logic [W-1:0]          nr;
  logic                  res_ok;
  logic [W-1:0]          res_sol;

  logic                  div_start;
  logic [W-1:0]          div_dividend;
  logic [W-1:0]          div_divisor;
  logic signed [TW-1:0]  div_t_init;
  logic signed [TW-1:0]  div_t_step;
  logic                  div_done;
  logic [W-1:0]          div_rem;
  logic signed [TW-1:0]  div_t;

  logic                  mul_start;
  logic                  mul_done;
  logic [W-1:0]          mul_product;
  logic signed [TW-1:0]  nr_ext;
  logic signed [TW-1:0]  t_red;

  assign in_accept = in_valid && !in_stall;
  assign nr_ext    = signed'({2'b00, nr});

  // cofactor lies within plus or minus the reduced modulus
  always_comb begin
    if (t0 < 0) begin
      t_red = t0 + nr_ext;
    end else if (t0 >= nr_ext) begin
      t_red = t0 - nr_ext;
    end else begin
      t_red = t0;
    end
  end

  lcs_divider #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .t_init    (div_t_init),
    .t_step    (div_t_step),
    .done      (div_done),
    .remainder (div_rem),
    .t_acc     (div_t)
  );

  lcs_mulmod #(.W(W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mult_a  (t_red[W-1:0]),
    .mult_b  (qb),
    .modv    (nr),
    .done    (mul_done),
    .product (mul_product)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = (modulus == '0) ? S_FINISH : S_EUC_CHK;
        end
      end
      S_EUC_CHK:    state_next = (r1 != '0) ? S_EUC_WAIT : S_RHS_WAIT;
      S_EUC_WAIT:   if (div_done) state_next = S_EUC_CHK;
      S_RHS_WAIT: begin
        if (div_done) begin
          state_next = (div_rem != '0) ? S_FINISH : S_MOD_LAUNCH;
        end
      end
      S_MOD_LAUNCH: state_next = S_MOD_WAIT;
      S_MOD_WAIT:   if (div_done) state_next = S_REDUCE;
      S_REDUCE:     state_next = S_MUL_WAIT;
      S_MUL_WAIT:   if (mul_done) state_next = S_FINISH;
      S_FINISH:     if (!out_valid || !out_stall) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // quotient runs use t_init 0 and t_step -1 so the accumulator holds q
  always_comb begin
    in_stall     = (state != S_IDLE);
    div_start    = 1'b0;
    div_dividend = r0;
    div_divisor  = r1;
    div_t_init   = t0;
    div_t_step   = t1;
    mul_start    = 1'b0;
    out_load     = 1'b0;
    case (state)
      S_EUC_CHK: begin
        div_start = 1'b1;
        if (r1 == '0) begin
          div_dividend = b_reg;
          div_divisor  = r0;
          div_t_init   = '0;
          div_t_step   = '1;
        end
      end
      S_MOD_LAUNCH: begin
        div_start    = 1'b1;
        div_dividend = n_reg;
        div_divisor  = r0;
        div_t_init   = '0;
        div_t_step   = '1;
      end
      S_REDUCE: mul_start = 1'b1;
      S_FINISH: out_load  = !out_valid || !out_stall;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          b_reg   <= rhs;
          n_reg   <= modulus;
          r0      <= modulus;
          r1      <= coef;
          t0      <= '0;
          t1      <= TW'(1);
          res_ok  <= 1'b0;
          res_sol <= '0;
        end
      end
      S_EUC_WAIT: begin
        if (div_done) begin
          r0 <= r1;
          r1 <= div_rem;
          t0 <= t1;
          t1 <= div_t;
        end
      end
      S_RHS_WAIT: if (div_done) qb <= div_t[W-1:0];
      S_MOD_WAIT: if (div_done) nr <= div_t[W-1:0];
      S_MUL_WAIT: begin
        if (mul_done) begin
          res_ok  <= 1'b1;
          res_sol <= mul_product;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      has_solution <= res_ok;
      solution     <= res_sol;
    end
  end

  `LCS_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state != S_IDLE)
  `LCS_ASSERT_IMP(a_fail_zero, out_valid && !has_solution, solution == '0)
  `LCS_ASSERT_IMP(a_mul_modulus, state == S_MUL_WAIT, nr != '0)

endmodule
